### rtl/wildcard_star_pattern_matcher_core_assert.svh
// Assertion macros for the checker file of the pattern matcher.
// No dependencies; included by bare file name.
`ifndef WILDCARD_STAR_PATTERN_MATCHER_CORE_ASSERT_SVH
`define WILDCARD_STAR_PATTERN_MATCHER_CORE_ASSERT_SVH

// Checked only outside reset.
`define WSPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define WSPM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wspm_pkg.sv
// Shared types and constants for the wildcard/star pattern matcher.
// No dependencies; imported by every module of the block.
package wspm_pkg;

   localparam int PAT_SLOTS       = 16;   // characters held by the two byte registers
   localparam int MAX_PATTERN_DEF = 16;
   localparam int LEN_W           = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 64;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_STAR = 8'h2A;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH     = 2'd0,
      CSR_BYTES_LOW  = 2'd1,
      CSR_BYTES_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       starts_text;
      logic       no_byte;
   } req_type;

   typedef struct packed {
      logic matched;
      logic alive;
   } rsp_type;

   // Decoded pattern as seen by the position update.
   typedef struct packed {
      logic [LEN_W-1:0]               len;    // saturated length
      logic [PAT_SLOTS-1:0]           star;   // position i is followed by '*'
      logic [PAT_SLOTS-1:0][7:0]      chars;
   } pat_info_type;

endpackage

### rtl/wspm_csr.sv
// Configuration registers and pattern decode (length saturation, star flags).
// Depends on wspm_pkg.
module wspm_csr
   import wspm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output pat_info_type          pat_info
);

   logic [LEN_W-1:0]      length_ff;
   logic [CSR_DATA_W-1:0] bytes_low_ff;
   logic [CSR_DATA_W-1:0] bytes_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         bytes_low_ff  <= '0;
         bytes_high_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LENGTH:     length_ff     <= csr_wdata[LEN_W-1:0];
            CSR_BYTES_LOW:  bytes_low_ff  <= csr_wdata;
            CSR_BYTES_HIGH: bytes_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pat_info.chars = {bytes_high_ff, bytes_low_ff};
      if (length_ff > LEN_W'(MAX_PATTERN)) begin
         pat_info.len = LEN_W'(MAX_PATTERN);
      end else begin
         pat_info.len = length_ff;
      end
      pat_info.star = '0;
      for (int i = 0; i < PAT_SLOTS - 1; i++) begin
         pat_info.star[i] = (LEN_W'(i + 2) <= pat_info.len) &&
                            (pat_info.chars[i + 1] == CHAR_STAR);
      end
   end

endmodule

### rtl/wspm_step.sv
// Combinational update of the active position set for one text item.
// Depends on wspm_pkg.
module wspm_step
   import wspm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  pat_info_type           pat_info,
   input  logic [MAX_PATTERN:0]   cur_set,
   input  req_type                item,
   output logic [MAX_PATTERN:0]   next_set,
   output rsp_type                result
);

   localparam int NPOS = MAX_PATTERN + 1;

   // Star-skip closure; chains run upwards so one ascending sweep suffices.
   function automatic logic [NPOS-1:0] close_set(input logic [NPOS-1:0] set_in,
                                                 input logic [PAT_SLOTS-1:0] star);
      logic [NPOS-1:0] s;
      s = set_in;
      for (int i = 0; i + 2 < NPOS; i++) begin
         if (s[i] && star[i]) begin
            s[i + 2] = 1'b1;
         end
      end
      return s;
   endfunction

   logic [NPOS-1:0] len_mask;
   logic [NPOS-1:0] len_onehot;
   logic [NPOS-1:0] start_set;
   logic [NPOS-1:0] act_set;
   logic [NPOS-1:0] moved;

   always_comb begin
      for (int j = 0; j < NPOS; j++) begin
         len_mask[j]   = (LEN_W'(j) <= pat_info.len);
         len_onehot[j] = (LEN_W'(j) == pat_info.len);
      end

      start_set = item.starts_text ? NPOS'(1) : cur_set;
      start_set = close_set(start_set & len_mask, pat_info.star);

      moved = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (start_set[i] && (LEN_W'(i) < pat_info.len) &&
             ((pat_info.chars[i] == CHAR_DOT) || (pat_info.chars[i] == item.text_byte))) begin
            if (pat_info.star[i]) begin
               moved[i] = 1'b1;
            end else begin
               moved[i + 1] = 1'b1;
            end
         end
      end

      if (item.no_byte) begin
         act_set = start_set;
      end else begin
         act_set = close_set(moved & len_mask, pat_info.star);
      end

      next_set       = act_set;
      result.matched = |(act_set & len_onehot);
      result.alive   = |act_set;
   end

endmodule

### rtl/wildcard_star_pattern_matcher_core.sv
// Top level of the wildcard/star pattern matcher.
// Depends on wspm_pkg, wspm_csr and wspm_step.
//
// Whole-string matcher for a pattern of up to MAX_PATTERN characters with '.'
// (any byte) and '*' (zero or more of the preceding element), loaded through
// the csr_ port. Each request transfer carries one text byte (or none, when
// no_byte is set, to just query) and starts_text restarts matching on a new
// text; each one yields exactly one response with matched and alive. Items
// are taken one per clock while the output register is free or draining: the
// request is registered, the active position set is updated through one stage
// of combinational logic, and the result lands in an output register that
// drives rsp_valid. The position-set register feeds each update back into the
// update of the next item. Config writes take effect on the next cycle; the
// user must make them only while no item is in flight, which the block
// itself does not enforce.
module wildcard_star_pattern_matcher_core
   import wspm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pat_info_type         pat_info;
   logic                 in_valid_ff;
   req_type              in_data_ff;
   logic [MAX_PATTERN:0] active_ff;
   logic [MAX_PATTERN:0] active_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;
   logic                 advance;

   wspm_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pat_info  (pat_info)
   );

   wspm_step #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_step (
      .pat_info (pat_info),
      .cur_set  (active_ff),
      .item     (in_data_ff),
      .next_set (active_in),
      .result   (rsp_data_in)
   );

   // Item in the input register moves on when the output slot is free or emptying.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            active_ff    <= active_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/wspm_checker.sv
// Port-level checks for the pattern matcher, bound to the top level.
// Depends on wspm_pkg and wildcard_star_pattern_matcher_core_assert.svh.
`include "wildcard_star_pattern_matcher_core_assert.svh"

module wspm_checker
   import wspm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data
);

   // A full match leaves position L active, so the set cannot be empty.
   `WSPM_ASSERT(a_match_implies_alive, clock, reset, rsp_valid |-> (!rsp_data.matched || rsp_data.alive), "matched reported with empty position set")

   // A fresh response needs a request transfer that has passed through the input register.
   `WSPM_ASSERT(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response without a matching request transfer")

   // With the output slot empty the input side must never stall.
   `WSPM_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready, "request stalled with no response pending")

   `WSPM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled response dropped or changed")

   `WSPM_ASSERT(a_req_hold, clock, reset, (req_valid && !req_ready) |=> (req_valid && $stable(req_data)), "stalled request dropped or changed")

endmodule

bind wildcard_star_pattern_matcher_core wspm_checker u_wspm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### dv/wspm_match_checker.sv
// Scoreboard for the wildcard/star pattern matcher: shadows the pattern registers,
// predicts each response from the request transfers and compares them in order.
// Depends on wspm_pkg.
`timescale 1ns / 100ps

module wspm_match_checker
   import wspm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    responses_checked,
   output int                    matches_seen
);

   typedef struct packed {
      logic [PAT_SLOTS:0] positions;
      rsp_type            rsp;
   } match_step_type;

   logic [LEN_W-1:0]        shadow_len;
   logic [CSR_DATA_W-1:0]   shadow_low;
   logic [CSR_DATA_W-1:0]   shadow_high;
   logic [PAT_SLOTS:0]      live_positions;
   rsp_type                 expected_rsp_q[$];

   function automatic logic is_star_elem(input int i, input int len, input logic [127:0] pat);
      if (i + 2 > len)
         return 1'b0;
      return pat[(i + 1) * 8 +: 8] == CHAR_STAR;
   endfunction

   function automatic logic [PAT_SLOTS:0] star_closure(input logic [PAT_SLOTS:0] set,
                                                       input int len, input logic [127:0] pat);
      logic [PAT_SLOTS:0] r;
      r = set;
      // ascending order so that chained stars propagate in one pass
      for (int i = 0; i + 2 <= len; i++)
         if (r[i] && is_star_elem(i, len, pat))
            r[i + 2] = 1'b1;
      return r;
   endfunction

   function automatic match_step_type predict_match(input logic [PAT_SLOTS:0] cur,
                                                    input req_type item,
                                                    input logic [LEN_W-1:0] len_cfg,
                                                    input logic [127:0] pat);
      match_step_type     res;
      int                 len;
      logic [PAT_SLOTS:0] mask;
      logic [PAT_SLOTS:0] act;
      logic [PAT_SLOTS:0] nxt;
      logic [7:0]         c;
      len  = (int'(len_cfg) > PAT_SLOTS) ? PAT_SLOTS : int'(len_cfg);
      mask = (PAT_SLOTS + 1)'(((PAT_SLOTS + 2)'(1) << (len + 1)) - 1);
      act  = item.starts_text ? (PAT_SLOTS + 1)'(1) : cur;
      act  = star_closure(act & mask, len, pat);
      if (!item.no_byte) begin
         nxt = '0;
         for (int i = 0; i < len; i++) begin
            c = pat[i * 8 +: 8];
            if (act[i] && (c == CHAR_DOT || c == item.text_byte)) begin
               if (is_star_elem(i, len, pat))
                  nxt[i] = 1'b1;
               else
                  nxt[i + 1] = 1'b1;
            end
         end
         act = star_closure(nxt & mask, len, pat);
      end
      res.positions   = act;
      res.rsp.matched = act[len];
      res.rsp.alive   = |act;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      match_step_type step;
      rsp_type        want;
      if (reset) begin
         shadow_len        <= '0;
         shadow_low        <= '0;
         shadow_high       <= '0;
         live_positions    <= '0;
         expected_rsp_q.delete();
         outstanding       <= 0;
         fail_count        = 0;
         responses_checked = 0;
         matches_seen      = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LENGTH:     shadow_len  <= csr_wdata[LEN_W-1:0];
               CSR_BYTES_LOW:  shadow_low  <= csr_wdata;
               CSR_BYTES_HIGH: shadow_high <= csr_wdata;
               default: ;
            endcase
         end
         // pop before push: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response %b/%b with nothing expected",
                                         rsp_data.matched, rsp_data.alive));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.matched !== want.matched)
                  report_mismatch($sformatf("matched got %b want %b",
                                            rsp_data.matched, want.matched));
               if (rsp_data.alive !== want.alive)
                  report_mismatch($sformatf("alive got %b want %b",
                                            rsp_data.alive, want.alive));
               responses_checked++;
               if (want.matched)
                  matches_seen++;
            end
         end
         if (req_valid && req_ready) begin
            step = predict_match(live_positions, req_data, shadow_len,
                                 {shadow_high, shadow_low});
            live_positions <= step.positions;
            expected_rsp_q.push_back(step.rsp);
         end
         outstanding <= expected_rsp_q.size();
      end
   end

endmodule

### dv/tb_wildcard_star_pattern_matcher_core.sv
// Testbench top for the wildcard/star pattern matcher: clock, reset, pattern
// loads, request/response traffic and the verdict. Depends on wspm_pkg,
// wspm_match_checker and the wildcard_star_pattern_matcher_core RTL.
`timescale 1ns / 100ps

module tb_wildcard_star_pattern_matcher_core;
   import wspm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int outstanding;
   int responses_checked;
   int matches_seen;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_request  = 1'b0;
   int requests_sent = 0;
   int pattern_loads = 0;
   int cycle_count   = 0;

   always #5 clock = ~clock;

   wildcard_star_pattern_matcher_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wspm_match_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .responses_checked (responses_checked),
      .matches_seen      (matches_seen)
   );

   function automatic req_type text_item(input logic [7:0] b, input logic start,
                                         input logic query);
      req_type r;
      r.text_byte   = b;
      r.starts_text = start;
      r.no_byte     = query;
      return r;
   endfunction

   // character 0 of the string lands in the lowest byte
   function automatic logic [127:0] from_text(input string s);
      logic [127:0] r;
      r = '0;
      for (int i = 0; i < s.len() && i < PAT_SLOTS; i++)
         r[i * 8 +: 8] = s[i];
      return r;
   endfunction

   // entry and exit at a rising edge
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [LEN_W-1:0] len, input logic [127:0] pat);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LENGTH;
      csr_wdata <= {{(CSR_DATA_W-LEN_W){1'b0}}, len};
      @(posedge clock);
      csr_index <= CSR_BYTES_LOW;
      csr_wdata <= pat[63:0];
      @(posedge clock);
      csr_index <= CSR_BYTES_HIGH;
      csr_wdata <= pat[127:64];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pattern_loads++;
   endtask

   task automatic send_noise(input int n);
      repeat (n)
         send_item(text_item(8'($urandom_range(255)), $urandom_range(9) == 0,
                             $urandom_range(5) == 0));
   endtask

   // mostly a text the pattern accepts, with the odd corrupted byte
   task automatic send_text(input logic [127:0] pat, input logic [LEN_W-1:0] len_cfg);
      logic [7:0] text_q[$];
      logic [7:0] c;
      int         sat;
      int         i;
      int         reps;
      sat = (int'(len_cfg) > PAT_SLOTS) ? PAT_SLOTS : int'(len_cfg);
      i = 0;
      while (i < sat) begin
         c = pat[i * 8 +: 8];
         reps = 1;
         if (i + 1 < sat && pat[(i + 1) * 8 +: 8] == CHAR_STAR)
            reps = $urandom_range(0, 3);
         repeat (reps)
            text_q.push_back((c == CHAR_DOT) ? 8'($urandom_range(255)) : c);
         i += (reps == 1 && !(i + 1 < sat && pat[(i + 1) * 8 +: 8] == CHAR_STAR)) ? 1 : 2;
      end
      if (text_q.size() > 0 && $urandom_range(3) == 0)
         text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(5) == 0)
         text_q.push_back(8'($urandom_range(255)));
      if (text_q.size() == 0 || $urandom_range(2) == 0)
         send_item(text_item(8'($urandom_range(255)), 1'b1, 1'b1));
      else
         send_item(text_item(text_q.pop_front(), 1'b1, 1'b0));
      while (text_q.size() > 0) begin
         if ($urandom_range(7) == 0)
            send_item(text_item(8'($urandom_range(255)), 1'b0, 1'b1));
         send_item(text_item(text_q.pop_front(), 1'b0, 1'b0));
      end
      if ($urandom_range(1) == 0)
         send_item(text_item(8'($urandom_range(255)), 1'b0, 1'b1));
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
      logic [127:0]     pat;
      logic [LEN_W-1:0] len;
      int               target;
      send_idle_pct = s_pct;
      stall_pct     = r_pct;
      target        = requests_sent + n_items;
      while (requests_sent < target) begin
         wait_idle();
         for (int i = 0; i < PAT_SLOTS; i++) begin
            case ($urandom_range(9))
               0, 1:    pat[i * 8 +: 8] = "a";
               2:       pat[i * 8 +: 8] = "b";
               3, 4:    pat[i * 8 +: 8] = CHAR_DOT;
               5, 6, 7: pat[i * 8 +: 8] = CHAR_STAR;
               8:       pat[i * 8 +: 8] = "c";
               default: pat[i * 8 +: 8] = 8'($urandom_range(255));
            endcase
         end
         if ($urandom_range(5) == 0)
            pat = {$urandom, $urandom, $urandom, $urandom};
         len = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(17, 31))
                                        : LEN_W'($urandom_range(0, 16));
         load_pattern(len, pat);
         repeat ($urandom_range(3, 6)) begin
            if ($urandom_range(4) == 0)
               send_noise($urandom_range(1, 6));
            else
               send_text(pat, len);
         end
      end
   endtask

   // response side; a long hold-off lets the block back up into the request side
   initial begin
      int held;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
               outstanding);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_LENGTH;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty pattern from reset: bytes before any text see an empty set
      send_item(text_item(8'h41, 1'b0, 1'b0));
      send_item(text_item(8'h00, 1'b0, 1'b1));
      send_item(text_item(8'hFF, 1'b1, 1'b1));
      send_item(text_item(8'h00, 1'b0, 1'b0));

      wait_idle();
      load_pattern(LEN_W'(4), from_text("a*.b"));
      send_item(text_item(8'h00, 1'b1, 1'b1));
      send_item(text_item("a", 1'b1, 1'b0));
      send_item(text_item("a", 1'b0, 1'b0));
      send_item(text_item(8'hFF, 1'b0, 1'b0));
      send_item(text_item("b", 1'b0, 1'b0));
      send_item(text_item(8'hFF, 1'b0, 1'b1));

      // length above the slot count saturates
      wait_idle();
      load_pattern(LEN_W'(31), from_text(".*.*.*.*.*.*.*.*"));
      send_item(text_item(8'h00, 1'b1, 1'b0));
      send_item(text_item(8'hFF, 1'b0, 1'b0));
      send_item(text_item(8'h00, 1'b0, 1'b1));

      // leading star is a plain literal
      wait_idle();
      load_pattern(LEN_W'(2), from_text("*a"));
      send_item(text_item(CHAR_STAR, 1'b1, 1'b0));
      send_item(text_item("a", 1'b0, 1'b0));

      // shorten the pattern part-way through a text
      wait_idle();
      load_pattern(LEN_W'(4), from_text("ab*c"));
      send_item(text_item("a", 1'b1, 1'b0));
      send_item(text_item("b", 1'b0, 1'b0));
      wait_idle();
      load_pattern(LEN_W'(2), from_text("ab*c"));
      send_item(text_item(8'h00, 1'b0, 1'b1));
      send_item(text_item("b", 1'b0, 1'b0));

      run_phase(0, 0, 75);
      run_phase(58, 0, 75);
      run_phase(0, 58, 75);
      run_phase(32, 32, 75);

      // receiver holds off while requests keep coming, so the input side stalls
      wait_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      load_pattern(LEN_W'(3), from_text("a.*"));
      hold_request = 1'b1;
      send_item(text_item("a", 1'b1, 1'b0));
      send_noise(15);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests under %0d pattern loads, four idle mixes and a long stall",
               requests_sent, pattern_loads);
      $display("Checked %0d responses, %0d of them full matches", responses_checked,
               matches_seen);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
